FILE: sv/hgcpf_pkg.sv
`default_nettype none

package hgcpf_pkg;

    localparam int NUM_CELLS_DEF      = 64;
    localparam int SLOTS_PER_CELL_DEF = 8;
    localparam int BODY_ID_BITS_DEF   = 10;

    localparam int CNT_BITS = 7;
    localparam logic [CNT_BITS-1:0] PAIR_CAP    = 7'd64;
    localparam logic [CNT_BITS-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [2:0] {
        ACT_ADD        = 3'd0,
        ACT_QUERY_BODY = 3'd1,
        ACT_QUERY_ALL  = 3'd2,
        ACT_LIST       = 3'd3,
        ACT_CLEAR      = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LATCH,
        CMD_CLR_STEP,
        CMD_FILL_RD,
        CMD_ADD_WR,
        CMD_SLOT_RD,
        CMD_QB_COUNT,
        CMD_QA_COUNT,
        CMD_REWIND,
        CMD_NEXT_CELL,
        CMD_STEP_I,
        CMD_EMIT_PAIR,
        CMD_EMIT_SINGLE
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       err;
        logic       out_free;
        logic       i_end;
        logic       cell_end;
        logic       done;
        logic       tot_zero;
        logic       fill_zero;
        logic       match;
        logic       pairs_done;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: sv/hashed_grid_cell_pair_finder.sv
// add: fill read, slot write, one result; clear: one fill zeroed per cell, then one result
// unused codes and errors: one result; query body: a counting pass over the slots, then
// a pass that reads each slot; list cell: one slot read per body; query all: a counting
// pass over the cells, then one over each cell and pair; the slot memory read port sets
// the pace; a new beat is taken once the last result is loaded, while it may still wait
// in the output; after reset the block stalls input while all cell fills are zeroed
`default_nettype none

module hashed_grid_cell_pair_finder #(
    parameter int NUM_CELLS      = hgcpf_pkg::NUM_CELLS_DEF,
    parameter int SLOTS_PER_CELL = hgcpf_pkg::SLOTS_PER_CELL_DEF,
    parameter int BODY_ID_BITS   = hgcpf_pkg::BODY_ID_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [6:0]              contact_limit,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic [2:0]              action,
    input  wire logic [5:0]              cell_index,
    input  wire logic [BODY_ID_BITS-1:0] body_id,
    input  wire logic [6:0]              cell_span,
    input  wire logic [6:0]              prior_count,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         pair_valid,
    output logic [BODY_ID_BITS-1:0]      first_body,
    output logic [BODY_ID_BITS-1:0]      second_body,
    output logic [6:0]                   result_count,
    output logic [1:0]                   status,
    output logic                         last
);
    import hgcpf_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    hgcpf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    hgcpf_dp #(
        .NUM_CELLS      (NUM_CELLS),
        .SLOTS_PER_CELL (SLOTS_PER_CELL),
        .BODY_ID_BITS   (BODY_ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .contact_limit (contact_limit),
        .action        (action),
        .cell_index    (cell_index),
        .body_id       (body_id),
        .cell_span     (cell_span),
        .prior_count   (prior_count),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .pair_valid    (pair_valid),
        .first_body    (first_body),
        .second_body   (second_body),
        .result_count  (result_count),
        .status        (status),
        .last          (last)
    );

endmodule

`default_nettype wire

FILE: sv/hgcpf_dp.sv
`default_nettype none

module hgcpf_dp #(
    parameter int NUM_CELLS      = hgcpf_pkg::NUM_CELLS_DEF,
    parameter int SLOTS_PER_CELL = hgcpf_pkg::SLOTS_PER_CELL_DEF,
    parameter int BODY_ID_BITS   = hgcpf_pkg::BODY_ID_BITS_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire hgcpf_pkg::dp_cmd_t      cmd,
    output hgcpf_pkg::dp_stat_t          stat,
    input  wire logic                    cfg_we,
    input  wire logic [6:0]              contact_limit,
    input  wire logic [2:0]              action,
    input  wire logic [5:0]              cell_index,
    input  wire logic [BODY_ID_BITS-1:0] body_id,
    input  wire logic [6:0]              cell_span,
    input  wire logic [6:0]              prior_count,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic                         pair_valid,
    output logic [BODY_ID_BITS-1:0]      first_body,
    output logic [BODY_ID_BITS-1:0]      second_body,
    output logic [6:0]                   result_count,
    output logic [1:0]                   status,
    output logic                         last
);
    import hgcpf_pkg::*;

    localparam int CELL_BITS  = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
    localparam int SCAN_BITS  = $clog2(NUM_CELLS + 1);
    localparam int FILL_BITS  = $clog2(SLOTS_PER_CELL + 1);
    localparam int SLOT_DEPTH = NUM_CELLS * SLOTS_PER_CELL;
    localparam int SADDR_BITS = $clog2(SLOT_DEPTH);
    localparam int PAIR_BITS  = 2 * FILL_BITS + CNT_BITS;

    logic [FILL_BITS-1:0]    fill_mem_reg [NUM_CELLS];
    logic [BODY_ID_BITS-1:0] slot_mem_reg [SLOT_DEPTH];

    logic [CNT_BITS-1:0]     limit_reg, limit_next;
    logic [2:0]              act_reg, act_next;
    logic                    err_reg, err_next;
    logic [BODY_ID_BITS-1:0] body_reg, body_next;
    logic [CNT_BITS-1:0]     prior_reg, prior_next;
    logic [CNT_BITS-1:0]     room_reg, room_next;
    logic [SCAN_BITS-1:0]    span_reg, span_next;
    logic [SCAN_BITS-1:0]    cell_reg, cell_next;
    logic [FILL_BITS-1:0]    i_reg, i_next;
    logic [FILL_BITS-1:0]    j_reg, j_next;
    logic [CNT_BITS-1:0]     n_reg, n_next;
    logic [CNT_BITS-1:0]     tot_reg, tot_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    pair_valid_reg, pair_valid_next;
    logic [BODY_ID_BITS-1:0] first_reg, first_next;
    logic [BODY_ID_BITS-1:0] second_reg, second_next;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic [1:0]              status_reg, status_next;
    logic                    last_reg, last_next;

    logic [FILL_BITS-1:0]    fill_rd_reg;
    logic [BODY_ID_BITS-1:0] slot_a_reg;
    logic [BODY_ID_BITS-1:0] slot_b_reg;

    logic [CELL_BITS-1:0]  cell_addr;
    logic [SADDR_BITS-1:0] addr_a;
    logic [SADDR_BITS-1:0] addr_b;
    logic [SADDR_BITS-1:0] addr_w;
    logic                  fill_we;
    logic [FILL_BITS-1:0]  fill_wdata;
    logic                  slot_we;
    logic                  cell_full;
    logic                  out_free;
    logic                  idx_bad;
    logic                  span_bad;
    logic [CNT_BITS-1:0]   limit_eff;
    logic [CNT_BITS-1:0]   room_in;
    logic [CNT_BITS-1:0]   pair_count;
    logic                  pair_last;
    logic [PAIR_BITS-1:0]  fill_w;
    logic [PAIR_BITS-1:0]  pair_sum;

    assign cell_addr = CELL_BITS'(cell_reg);
    assign addr_a    = SADDR_BITS'(cell_addr * SLOTS_PER_CELL + i_reg);
    assign addr_b    = SADDR_BITS'(cell_addr * SLOTS_PER_CELL + j_reg);
    assign addr_w    = SADDR_BITS'(cell_addr * SLOTS_PER_CELL + fill_rd_reg);
    assign cell_full = fill_rd_reg >= FILL_BITS'(SLOTS_PER_CELL);
    assign out_free  = !out_valid_reg || !out_stall;
    assign idx_bad   = 32'(cell_index) >= NUM_CELLS;
    assign span_bad  = 32'(cell_span) > NUM_CELLS;
    assign limit_eff = (limit_reg > PAIR_CAP) ? PAIR_CAP : limit_reg;
    assign room_in   = (limit_eff > prior_count) ? (limit_eff - prior_count) : '0;
    assign pair_count = prior_reg + tot_reg;
    assign pair_last  = ({1'b0, n_reg} + 1'b1) == {1'b0, tot_reg};

    // pairs in one cell, fill*(fill-1)/2, added to the running total
    assign fill_w   = PAIR_BITS'(fill_rd_reg);
    assign pair_sum = PAIR_BITS'(tot_reg) + ((fill_w * (fill_w - 1'b1)) >> 1);

    always_comb
    begin
        stat.act        = act_reg;
        stat.err        = err_reg;
        stat.out_free   = out_free;
        stat.i_end      = i_reg >= fill_rd_reg;
        stat.cell_end   = cell_reg == span_reg;
        stat.done       = n_reg == tot_reg;
        stat.tot_zero   = tot_reg == '0;
        stat.fill_zero  = fill_rd_reg == '0;
        stat.match      = slot_a_reg == body_reg;
        stat.pairs_done = ({1'b0, i_reg} + 1'b1) >= {1'b0, fill_rd_reg};
    end

    always_comb
    begin
        limit_next      = limit_reg;
        act_next        = act_reg;
        err_next        = err_reg;
        body_next       = body_reg;
        prior_next      = prior_reg;
        room_next       = room_reg;
        span_next       = span_reg;
        cell_next       = cell_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        n_next          = n_reg;
        tot_next        = tot_reg;
        out_valid_next  = out_valid_reg;
        pair_valid_next = pair_valid_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        fill_we         = 1'b0;
        fill_wdata      = '0;
        slot_we         = 1'b0;

        if (cfg_we)
        begin
            limit_next = contact_limit;
        end

        // output beat taken
        if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (cmd)
            CMD_NONE:
            begin
            end
            CMD_LATCH:
            begin
                act_next   = action;
                body_next  = body_id;
                prior_next = prior_count;
                room_next  = room_in;
                span_next  = SCAN_BITS'(cell_span);
                i_next     = '0;
                j_next     = FILL_BITS'(1);
                n_next     = '0;
                tot_next   = '0;
                priority if (action == ACT_ADD || action == ACT_QUERY_BODY ||
                             action == ACT_LIST)
                begin
                    err_next  = idx_bad;
                    cell_next = SCAN_BITS'(cell_index);
                end
                else if (action == ACT_QUERY_ALL || action == ACT_CLEAR)
                begin
                    err_next  = span_bad;
                    cell_next = '0;
                end
                else
                begin
                    err_next  = 1'b0;
                    cell_next = '0;
                end
            end
            CMD_CLR_STEP:
            begin
                fill_we    = 1'b1;
                fill_wdata = '0;
                cell_next  = cell_reg + 1'b1;
            end
            CMD_FILL_RD:
            begin
                i_next = '0;
                j_next = FILL_BITS'(1);
            end
            CMD_ADD_WR:
            begin
                if (!cell_full)
                begin
                    fill_we    = 1'b1;
                    fill_wdata = fill_rd_reg + 1'b1;
                    slot_we    = 1'b1;
                end
            end
            CMD_SLOT_RD:
            begin
            end
            CMD_QB_COUNT:
            begin
                if (!stat.match && tot_reg < room_reg)
                begin
                    tot_next = tot_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
            end
            CMD_QA_COUNT:
            begin
                tot_next  = (pair_sum > PAIR_BITS'(room_reg)) ? room_reg
                                                              : CNT_BITS'(pair_sum);
                cell_next = cell_reg + 1'b1;
            end
            CMD_REWIND:
            begin
                if (act_reg == ACT_QUERY_ALL)
                begin
                    cell_next = '0;
                end
                i_next = '0;
                j_next = FILL_BITS'(1);
                n_next = '0;
            end
            CMD_NEXT_CELL:
            begin
                cell_next = cell_reg + 1'b1;
                i_next    = '0;
                j_next    = FILL_BITS'(1);
            end
            CMD_STEP_I:
            begin
                i_next = i_reg + 1'b1;
            end
            CMD_EMIT_PAIR:
            begin
                out_valid_next  = 1'b1;
                pair_valid_next = 1'b1;
                status_next     = ST_OK;
                priority if (act_reg == ACT_LIST)
                begin
                    first_next  = slot_a_reg;
                    second_next = '0;
                    count_next  = CNT_BITS'(fill_rd_reg);
                    last_next   = ({1'b0, i_reg} + 1'b1) == {1'b0, fill_rd_reg};
                    i_next      = i_reg + 1'b1;
                end
                else if (act_reg == ACT_QUERY_BODY)
                begin
                    first_next  = body_reg;
                    second_next = slot_a_reg;
                    count_next  = pair_count;
                    last_next   = pair_last;
                    n_next      = n_reg + 1'b1;
                    i_next      = i_reg + 1'b1;
                end
                else
                begin
                    first_next  = slot_a_reg;
                    second_next = slot_b_reg;
                    count_next  = pair_count;
                    last_next   = pair_last;
                    n_next      = n_reg + 1'b1;
                    // walk j over the row, then move to the next i
                    if (({1'b0, j_reg} + 1'b1) >= {1'b0, fill_rd_reg})
                    begin
                        i_next = i_reg + 1'b1;
                        j_next = i_reg + FILL_BITS'(2);
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
            end
            CMD_EMIT_SINGLE:
            begin
                out_valid_next  = 1'b1;
                pair_valid_next = 1'b0;
                first_next      = '0;
                second_next     = '0;
                count_next      = '0;
                last_next       = 1'b1;
                priority if (err_reg)
                begin
                    status_next = ST_RANGE;
                end
                else if (act_reg == ACT_ADD && cell_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RESET;
            act_reg       <= '0;
            err_reg       <= 1'b0;
            room_reg      <= '0;
            span_reg      <= SCAN_BITS'(NUM_CELLS);
            cell_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            tot_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            limit_reg     <= limit_next;
            act_reg       <= act_next;
            err_reg       <= err_next;
            room_reg      <= room_next;
            span_reg      <= span_next;
            cell_reg      <= cell_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            n_reg         <= n_next;
            tot_reg       <= tot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        body_reg       <= body_next;
        prior_reg      <= prior_next;
        pair_valid_reg <= pair_valid_next;
        first_reg      <= first_next;
        second_reg     <= second_next;
        count_reg      <= count_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem_reg[cell_addr] <= fill_wdata;
        end
        if (slot_we)
        begin
            slot_mem_reg[addr_w] <= body_reg;
        end
        if (cmd == CMD_FILL_RD)
        begin
            fill_rd_reg <= fill_mem_reg[cell_addr];
        end
        if (cmd == CMD_SLOT_RD)
        begin
            slot_a_reg <= slot_mem_reg[addr_a];
            slot_b_reg <= slot_mem_reg[addr_b];
        end
    end

    assign out_valid    = out_valid_reg;
    assign pair_valid   = pair_valid_reg;
    assign first_body   = first_reg;
    assign second_body  = second_reg;
    assign result_count = count_reg;
    assign status       = status_reg;
    assign last         = last_reg;

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd == CMD_EMIT_PAIR || cmd == CMD_EMIT_SINGLE) |-> out_free)
        else $error("result loaded over a beat still waiting");

    a_n_le_tot: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= tot_reg)
        else $error("more pairs sent than counted");

    a_tot_le_room: assert property (@(posedge clk) disable iff (!rst_n)
        tot_reg <= room_reg)
        else $error("pair total exceeds contact room");

    a_pair_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && pair_valid_reg) |-> (count_reg != '0))
        else $error("valid pair with zero count");

endmodule

`default_nettype wire

FILE: sv/hgcpf_ctrl.sv
`default_nettype none

module hgcpf_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire hgcpf_pkg::dp_stat_t stat,
    output hgcpf_pkg::dp_cmd_t       cmd
);
    import hgcpf_pkg::*;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DISP,
        S_ADD,
        S_CLR,
        S_SINGLE,
        S_QB_CHK,
        S_QB_CNT,
        S_QB_GO,
        S_QB_EM,
        S_QA_NXT,
        S_QA_CNT,
        S_QA_GO,
        S_QA_CELL,
        S_QA_EM,
        S_LS_GO,
        S_LS_EM
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg, stall_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        unique case (state_reg)
            S_INIT:
            begin
                // clearing pass over every cell fill after reset
                if (stat.cell_end)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd = CMD_CLR_STEP;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LATCH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                priority if (stat.err)
                begin
                    state_next = S_SINGLE;
                end
                else if (stat.act == ACT_ADD)
                begin
                    cmd        = CMD_FILL_RD;
                    state_next = S_ADD;
                end
                else if (stat.act == ACT_QUERY_BODY)
                begin
                    cmd        = CMD_FILL_RD;
                    state_next = S_QB_CHK;
                end
                else if (stat.act == ACT_QUERY_ALL)
                begin
                    state_next = S_QA_NXT;
                end
                else if (stat.act == ACT_LIST)
                begin
                    cmd        = CMD_FILL_RD;
                    state_next = S_LS_GO;
                end
                else if (stat.act == ACT_CLEAR)
                begin
                    state_next = S_CLR;
                end
                else
                begin
                    state_next = S_SINGLE;
                end
            end
            S_ADD:
            begin
                cmd        = CMD_ADD_WR;
                state_next = S_SINGLE;
            end
            S_CLR:
            begin
                if (stat.cell_end)
                begin
                    state_next = S_SINGLE;
                end
                else
                begin
                    cmd = CMD_CLR_STEP;
                end
            end
            S_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT_SINGLE;
                    state_next = S_IDLE;
                end
            end
            S_QB_CHK:
            begin
                // first pass counts the pairs so every beat carries the total
                if (stat.i_end)
                begin
                    cmd        = CMD_REWIND;
                    state_next = S_QB_GO;
                end
                else
                begin
                    cmd        = CMD_SLOT_RD;
                    state_next = S_QB_CNT;
                end
            end
            S_QB_CNT:
            begin
                cmd        = CMD_QB_COUNT;
                state_next = S_QB_CHK;
            end
            S_QB_GO:
            begin
                if (stat.done)
                begin
                    state_next = stat.tot_zero ? S_SINGLE : S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SLOT_RD;
                    state_next = S_QB_EM;
                end
            end
            S_QB_EM:
            begin
                if (stat.match)
                begin
                    cmd        = CMD_STEP_I;
                    state_next = S_QB_GO;
                end
                else if (stat.out_free)
                begin
                    cmd        = CMD_EMIT_PAIR;
                    state_next = S_QB_GO;
                end
            end
            S_QA_NXT:
            begin
                if (stat.cell_end)
                begin
                    cmd        = CMD_REWIND;
                    state_next = S_QA_GO;
                end
                else
                begin
                    cmd        = CMD_FILL_RD;
                    state_next = S_QA_CNT;
                end
            end
            S_QA_CNT:
            begin
                cmd        = CMD_QA_COUNT;
                state_next = S_QA_NXT;
            end
            S_QA_GO:
            begin
                if (stat.done)
                begin
                    state_next = stat.tot_zero ? S_SINGLE : S_IDLE;
                end
                else
                begin
                    cmd        = CMD_FILL_RD;
                    state_next = S_QA_CELL;
                end
            end
            S_QA_CELL:
            begin
                priority if (stat.done)
                begin
                    state_next = S_IDLE;
                end
                else if (stat.pairs_done)
                begin
                    cmd        = CMD_NEXT_CELL;
                    state_next = S_QA_GO;
                end
                else
                begin
                    cmd        = CMD_SLOT_RD;
                    state_next = S_QA_EM;
                end
            end
            S_QA_EM:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT_PAIR;
                    state_next = S_QA_CELL;
                end
            end
            S_LS_GO:
            begin
                if (stat.i_end)
                begin
                    state_next = stat.fill_zero ? S_SINGLE : S_IDLE;
                end
                else
                begin
                    cmd        = CMD_SLOT_RD;
                    state_next = S_LS_EM;
                end
            end
            S_LS_EM:
            begin
                if (stat.out_free)
                begin
                    cmd        = CMD_EMIT_PAIR;
                    state_next = S_LS_GO;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign stall_next = state_next != S_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= stall_next;
        end
    end

    assign in_stall = stall_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
module tb;
    import hgcpf_pkg::*;

    localparam int NCELL       = NUM_CELLS_DEF;
    localparam int SLOTS       = SLOTS_PER_CELL_DEF;
    localparam int BW          = BODY_ID_BITS_DEF;
    localparam int HOT         = 6;
    localparam int RX_HOLD     = 300;
    localparam int WD_LIMIT    = 2000;
    localparam int DRAIN_WAIT  = 20;
    localparam int PHASE_ITEMS = 68;
    localparam int NUM_PHASES  = 6;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;

    typedef struct packed {
        logic          pv;
        logic [BW-1:0] a;
        logic [BW-1:0] b;
        logic [6:0]    cnt;
        logic [1:0]    st;
        logic          lst;
    } grid_beat_t;

    typedef struct packed {
        logic [2:0]    act;
        logic [5:0]    idx;
        logic [BW-1:0] body;
        logic [6:0]    span;
        logic [6:0]    prior;
        logic          typed;
        logic [1:0]    st;
    } grid_op_t;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [6:0]    contact_limit;
    logic          in_valid;
    logic          in_stall;
    logic [2:0]    action;
    logic [5:0]    cell_index;
    logic [BW-1:0] body_id;
    logic [6:0]    cell_span;
    logic [6:0]    prior_count;
    logic          out_valid;
    logic          out_stall;
    logic          pair_valid;
    logic [BW-1:0] first_body;
    logic [BW-1:0] second_body;
    logic [6:0]    result_count;
    logic [1:0]    status;
    logic          last;

    // shadow of the grid
    int            fill_m [NCELL];
    logic [BW-1:0] slot_m [NCELL][SLOTS];
    logic [6:0]    limit_m;

    grid_beat_t    step_beats[$];
    grid_beat_t    grid_out_q[$];

    bit rx_hold_go = 1'b0;
    int quiet_cycles = 0;
    int n_errs = 0;
    int n_items = 0;
    int n_beats = 0;
    int n_bodies = 0;
    int n_full = 0;
    int n_range = 0;
    int n_holds = 0;

    hashed_grid_cell_pair_finder u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .contact_limit(contact_limit),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .cell_index   (cell_index),
        .body_id      (body_id),
        .cell_span    (cell_span),
        .prior_count  (prior_count),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pair_valid   (pair_valid),
        .first_body   (first_body),
        .second_body  (second_body),
        .result_count (result_count),
        .status       (status),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // works out the beats one op causes and updates the shadow grid
    task automatic grid_step(input grid_op_t op);
        grid_beat_t bt;
        int         tally;
        int         lim;
        logic [6:0] cnt;
        lim = (limit_m > PAIR_CAP) ? int'(PAIR_CAP) : int'(limit_m);
        tally = int'(op.prior);
        cnt = '0;
        bt = '0;
        step_beats.delete();
        case (op.act)
            ACT_ADD:
            begin
                if (fill_m[op.idx] >= SLOTS)
                    bt.st = ST_FULL;
                else
                begin
                    slot_m[op.idx][fill_m[op.idx]] = op.body;
                    fill_m[op.idx]++;
                end
                step_beats = {step_beats, bt};
            end
            ACT_QUERY_BODY:
            begin
                for (int i = 0; i < fill_m[op.idx] && tally < lim; i++)
                begin
                    // a body never pairs with itself
                    if (slot_m[op.idx][i] != op.body)
                    begin
                        bt.pv = 1'b1;
                        bt.a  = op.body;
                        bt.b  = slot_m[op.idx][i];
                        step_beats = {step_beats, bt};
                        tally++;
                    end
                end
                cnt = (tally == op.prior) ? 7'd0 : 7'(tally);
            end
            ACT_QUERY_ALL:
            begin
                if (op.span > NCELL)
                begin
                    bt.st = ST_RANGE;
                    step_beats = {step_beats, bt};
                end
                else
                begin
                    for (int c = 0; c < op.span && tally < lim; c++)
                        for (int i = 0; i + 1 < fill_m[c] && tally < lim; i++)
                            for (int j = i + 1; j < fill_m[c] && tally < lim; j++)
                            begin
                                bt.pv = 1'b1;
                                bt.a  = slot_m[c][i];
                                bt.b  = slot_m[c][j];
                                step_beats = {step_beats, bt};
                                tally++;
                            end
                    cnt = (tally == op.prior) ? 7'd0 : 7'(tally);
                end
            end
            ACT_LIST:
            begin
                for (int i = 0; i < fill_m[op.idx]; i++)
                begin
                    bt.pv = 1'b1;
                    bt.a  = slot_m[op.idx][i];
                    step_beats = {step_beats, bt};
                end
                cnt = 7'(fill_m[op.idx]);
            end
            ACT_CLEAR:
            begin
                if (op.span > NCELL)
                    bt.st = ST_RANGE;
                else
                    for (int c = 0; c < op.span; c++)
                        fill_m[c] = 0;
                step_beats = {step_beats, bt};
            end
            default:
                step_beats = {step_beats, bt};
        endcase
        // nothing to emit still gives one empty beat
        if (step_beats.size() == 0)
            step_beats = {step_beats, bt};
        foreach (step_beats[k])
        begin
            step_beats[k].cnt = cnt;
            step_beats[k].lst = (k == step_beats.size() - 1);
        end
    endtask

    function automatic grid_op_t row(logic [2:0] act, logic [5:0] idx, logic [BW-1:0] body,
                                     logic [6:0] span, logic [6:0] prior, logic typed,
                                     logic [1:0] st);
        grid_op_t op;
        op.act   = act;
        op.idx   = idx;
        op.body  = body;
        op.span  = span;
        op.prior = prior;
        op.typed = typed;
        op.st    = st;
        return op;
    endfunction

    // mostly adds and queries on a few hot cells so cells fill up and pair
    function automatic grid_op_t rand_op();
        grid_op_t op;
        int       r;
        op = '0;
        op.body = BW'($urandom_range(0, (1 << BW) - 1));
        op.idx  = ($urandom_range(0, 4) != 0) ? 6'($urandom_range(0, HOT - 1))
                                               : 6'($urandom_range(0, NCELL - 1));
        r = $urandom_range(0, 9);
        if (r < 7)
            op.prior = 7'($urandom_range(0, 8));
        else if (r < 9)
            op.prior = 7'($urandom_range(40, 64));
        else
            op.prior = 7'($urandom_range(0, 127));
        r = $urandom_range(0, 99);
        if (r < 36)
        begin
            op.act = ACT_ADD;
            if ($urandom_range(0, 2) == 0)
                op.body = BW'($urandom_range(0, 7));
        end
        else if (r < 56)
        begin
            op.act = ACT_QUERY_BODY;
            if (fill_m[op.idx] != 0 && $urandom_range(0, 1) == 1)
                op.body = slot_m[op.idx][$urandom_range(0, fill_m[op.idx] - 1)];
        end
        else if (r < 72)
        begin
            op.act = ACT_QUERY_ALL;
            r = $urandom_range(0, 19);
            if (r < 12)
                op.span = 7'($urandom_range(1, HOT));
            else if (r < 17)
                op.span = 7'($urandom_range(0, NCELL));
            else if (r < 19)
                op.span = 7'(NCELL);
            else
                op.span = 7'($urandom_range(NCELL + 1, 127));
        end
        else if (r < 86)
            op.act = ACT_LIST;
        else if (r < 94)
        begin
            op.act = ACT_CLEAR;
            r = $urandom_range(0, 9);
            if (r < 5)
                op.span = 7'($urandom_range(0, 2));
            else if (r < 8)
                op.span = 7'($urandom_range(0, NCELL));
            else
                op.span = 7'($urandom_range(NCELL + 1, 127));
        end
        else
        begin
            op.act  = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
            op.span = 7'($urandom_range(0, 127));
        end
        return op;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic offer(input grid_op_t op, input int gap);
        grid_beat_t bt;
        repeat (gap)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        action      <= op.act;
        cell_index  <= op.idx;
        body_id     <= op.body;
        cell_span   <= op.span;
        prior_count <= op.prior;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        n_items++;
        grid_step(op);
        if (op.typed)
        begin
            bt = '0;
            bt.st  = op.st;
            bt.lst = 1'b1;
            grid_out_q = {grid_out_q, bt};
        end
        else
            foreach (step_beats[k])
                grid_out_q = {grid_out_q, step_beats[k]};
    endtask

    task automatic quiesce();
        @(negedge clk);
        in_valid <= 1'b0;
        while (grid_out_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_limit(input logic [6:0] v);
        @(negedge clk);
        cfg_valid     <= 1'b1;
        contact_limit <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        limit_m = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // receiver stall pattern
    initial
    begin : rx_drive
        int   left;
        logic val;
        out_stall = 1'b0;
        left = 0;
        val = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_go)
            begin
                rx_hold_go = 1'b0;
                n_holds++;
                val = 1'b1;
                left = RX_HOLD;
            end
            else if (left == 0)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2, 3, 4, 5, 6, 7, 8:
                    begin
                        val = 1'b0;
                        left = $urandom_range(1, 24);
                    end
                    17, 18, 19:
                    begin
                        val = 1'b1;
                        left = $urandom_range(8, 40);
                    end
                    default:
                    begin
                        val = 1'b1;
                        left = $urandom_range(1, 3);
                    end
                endcase
            end
            left--;
            out_stall <= val;
        end
    end

    always @(posedge clk)
    begin
        grid_beat_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            n_beats++;
            if (grid_out_q.size() == 0)
            begin
                $error("result beat with nothing expected");
                n_errs++;
            end
            else
            begin
                want = grid_out_q.pop_front();
                if (want.pv)
                    n_bodies++;
                if (want.st == ST_FULL)
                    n_full++;
                if (want.st == ST_RANGE)
                    n_range++;
                if (pair_valid !== want.pv)
                begin
                    $error("pair_valid exp %0d got %0d", want.pv, pair_valid);
                    n_errs++;
                end
                if (first_body !== want.a)
                begin
                    $error("first_body exp %0d got %0d", want.a, first_body);
                    n_errs++;
                end
                if (second_body !== want.b)
                begin
                    $error("second_body exp %0d got %0d", want.b, second_body);
                    n_errs++;
                end
                if (result_count !== want.cnt)
                begin
                    $error("result_count exp %0d got %0d", want.cnt, result_count);
                    n_errs++;
                end
                if (status !== want.st)
                begin
                    $error("status exp %0d got %0d", want.st, status);
                    n_errs++;
                end
                if (last !== want.lst)
                begin
                    $error("last exp %0d got %0d", want.lst, last);
                    n_errs++;
                end
            end
        end
    end

    // watchdog on cycles with no beat moving anywhere
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WD_LIMIT)
        begin
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : main_seq
        grid_op_t   plan[$];
        logic [6:0] limits [NUM_PHASES];
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        contact_limit = '0;
        in_valid      = 1'b0;
        action        = ACT_ADD;
        cell_index    = '0;
        body_id       = '0;
        cell_span     = '0;
        prior_count   = '0;
        foreach (fill_m[c])
            fill_m[c] = 0;
        limit_m = LIMIT_RESET;
        limits[0] = 7'd64;
        limits[1] = 7'd0;
        limits[2] = 7'd127;
        limits[3] = 7'd1;
        limits[4] = 7'($urandom_range(2, 63));
        limits[5] = 7'd64;

        // empty grid, range errors and unused codes
        plan = {plan, row(ACT_LIST,       6'd0,  10'd0,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_QUERY_ALL,  6'd0,  10'd0,    7'd64,  7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_QUERY_BODY, 6'd63, 10'd1023, 7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_CLEAR,      6'd0,  10'd0,    7'd65,  7'd0,   1'b1, ST_RANGE)};
        plan = {plan, row(ACT_QUERY_ALL,  6'd0,  10'd0,    7'd127, 7'd0,   1'b1, ST_RANGE)};
        plan = {plan, row(ACT_SPARE_LO,   6'd63, 10'd1023, 7'd127, 7'd127, 1'b1, ST_OK)};
        plan = {plan, row(ACT_SPARE_LO + 3'd1, 6'd0, 10'd0, 7'd0,  7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_SPARE_HI,   6'd21, 10'd682,  7'd85,  7'd42,  1'b1, ST_OK)};
        // fill the top cell, one id twice
        plan = {plan, row(ACT_ADD,        6'd63, 10'd0,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd1023, 7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd5,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd5,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd512,  7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd1,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd2,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd3,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_ADD,        6'd63, 10'd7,    7'd0,   7'd0,   1'b1, ST_FULL)};
        plan = {plan, row(ACT_QUERY_BODY, 6'd63, 10'd5,    7'd0,   7'd0,   1'b0, ST_OK)};
        plan = {plan, row(ACT_QUERY_BODY, 6'd63, 10'd5,    7'd0,   7'd64,  1'b1, ST_OK)};
        plan = {plan, row(ACT_QUERY_ALL,  6'd0,  10'd0,    7'd64,  7'd60,  1'b0, ST_OK)};
        plan = {plan, row(ACT_LIST,       6'd63, 10'd0,    7'd0,   7'd0,   1'b0, ST_OK)};
        plan = {plan, row(ACT_CLEAR,      6'd0,  10'd0,    7'd0,   7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_CLEAR,      6'd0,  10'd0,    7'd64,  7'd0,   1'b1, ST_OK)};
        plan = {plan, row(ACT_LIST,       6'd63, 10'd0,    7'd0,   7'd0,   1'b1, ST_OK)};

        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[k])
            offer(plan[k], pick_gap());

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            quiesce();
            set_limit(limits[p]);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                // long receiver hold-off while the sender keeps sending back to back
                if (p == 2 && k == 10)
                    rx_hold_go = 1'b1;
                offer(rand_op(), (p == 2 && k >= 10 && k < 50) ? 0 : pick_gap());
            end
        end
        quiesce();
        repeat (DRAIN_WAIT)
            @(posedge clk);

        $display("summary: %0d ops in, %0d result beats (%0d carrying bodies)",
                 n_items, n_beats, n_bodies);
        $display("summary: %0d full, %0d range, limits 64 0 127 1 %0d 64, %0d long hold-off",
                 n_full, n_range, limits[4], n_holds);
        if (n_errs == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
